// ===== rtl/fan_stall_supervisor_unit_assert.svh =====
// Assertion macros for the fan stall supervisor checker.
// Depends on nothing; included by the checker file.
`ifndef FAN_STALL_SUPERVISOR_UNIT_ASSERT_SVH
`define FAN_STALL_SUPERVISOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fss assertion failed");

// next-cycle implication
`define FSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fss assertion failed");

`endif

// ===== rtl/fss_pkg.sv =====
// Shared types and constants of the fan stall supervisor.
// No dependencies.
package fss_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_DELAY  = 1'b1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
	localparam logic [31:0] CUTOFF_RESET  = 32'd5000;

	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [7:0] PCT_MAX = 8'd100;

	typedef struct packed {
		logic        operation;
		logic        power_on_request;
		logic [7:0]  speed_request;
		logic [15:0] pulse_count;
		logic [15:0] step_ms;
	} req_t;

	typedef struct packed {
		logic       power_enable;
		logic [6:0] applied_speed;
		logic       fault_new;
	} rsp_t;

	typedef struct packed {
		logic [31:0] stall_timeout;
		logic [31:0] cutoff_delay;
	} cfg_t;

endpackage

// ===== rtl/fss_if.sv =====
// Request and result channel interfaces of the fan stall supervisor.
// No dependencies.
interface fss_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        power_on_request;
	logic [7:0]  speed_request;
	logic [15:0] pulse_count;
	logic [15:0] step_ms;

	modport source(output valid, operation, power_on_request, speed_request, pulse_count,
		step_ms, input ready);
	modport sink(input valid, operation, power_on_request, speed_request, pulse_count,
		step_ms, output ready);
endinterface

interface fss_rsp_if;
	logic       valid;
	logic       ready;
	logic       power_enable;
	logic [6:0] applied_speed;
	logic       fault_new;

	modport source(output valid, power_enable, applied_speed, fault_new, input ready);
	modport sink(input valid, power_enable, applied_speed, fault_new, output ready);
endinterface

// ===== rtl/fss_cfg_regs.sv =====
// Configuration registers: stall timeout and cutoff delay.
// Depends on fss_pkg.
module fss_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output fss_pkg::cfg_t                    cfg
);

	fss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_timeout <= fss_pkg::TIMEOUT_RESET;
			cfg_q.cutoff_delay  <= fss_pkg::CUTOFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fss_pkg::REG_STALL_TIMEOUT: cfg_q.stall_timeout <= cfg_wdata;
				fss_pkg::REG_CUTOFF_DELAY:  cfg_q.cutoff_delay  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fss_core.sv =====
// Stall watchdog state and per-request result logic.
// Depends on fss_pkg.
module fss_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fss_pkg::req_t req,
	input  fss_pkg::cfg_t cfg,
	output fss_pkg::rsp_t rsp
);

	logic        fault_q;
	logic [31:0] cutoff_left_q;
	logic [31:0] stall_elapsed_q;

	logic        fault_d;
	logic [31:0] cutoff_left_d;
	logic [31:0] stall_elapsed_d;

	logic [6:0]  pct;
	logic [32:0] stall_sum;
	logic [31:0] stall_sat;
	logic [31:0] dt_ext;

	assign pct       = (req.speed_request > fss_pkg::PCT_MAX) ? fss_pkg::PCT_MAX[6:0]
		: req.speed_request[6:0];
	assign dt_ext    = {16'd0, req.step_ms};
	assign stall_sum = {1'b0, stall_elapsed_q} + {1'b0, dt_ext};
	assign stall_sat = stall_sum[32] ? '1 : stall_sum[31:0];

	always_comb begin
		fault_d         = fault_q;
		cutoff_left_d   = cutoff_left_q;
		stall_elapsed_d = stall_elapsed_q;
		rsp             = '0;
		if (req.operation == fss_pkg::OP_CLEAR) begin
			fault_d         = 1'b0;
			cutoff_left_d   = '0;
			stall_elapsed_d = '0;
		end else if (fault_q) begin
			if (cutoff_left_q > dt_ext) begin
				cutoff_left_d    = cutoff_left_q - dt_ext;
				rsp.power_enable = 1'b1;
			end else begin
				cutoff_left_d = '0;
			end
		end else if (!req.power_on_request) begin
			stall_elapsed_d = '0;
		end else begin
			rsp.power_enable  = 1'b1;
			rsp.applied_speed = pct;
			if (pct == 7'd0 || req.pulse_count != 16'd0) begin
				stall_elapsed_d = '0;
			end else begin
				stall_elapsed_d = stall_sat;
				if (stall_sat >= cfg.stall_timeout) begin
					fault_d           = 1'b1;
					cutoff_left_d     = cfg.cutoff_delay;
					rsp.applied_speed = '0;
					rsp.fault_new     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q         <= 1'b0;
			cutoff_left_q   <= '0;
			stall_elapsed_q <= '0;
		end else if (en) begin
			fault_q         <= fault_d;
			cutoff_left_q   <= cutoff_left_d;
			stall_elapsed_q <= stall_elapsed_d;
		end
	end

endmodule

// ===== rtl/fan_stall_supervisor_unit.sv =====
// Fan stall supervisor: stall watchdog for a tach-monitored fan.
// Request channel (req) carries one time step or a clear; result channel (rsp)
// returns power enable, applied speed percent and a new-fault flag, one result
// per request, in order.
// Both channels are valid/ready; a transfer happens when both are high.
// Configuration: cfg_we with cfg_index 0 writes the stall timeout, index 1 the
// cutoff delay (both in ms); write only while no request is in flight.
// Pipeline: a taken request waits in the input register (req_s1); its result is
// registered into the result register (rsp_q) when rsp can advance.
// Throughput: one request per cycle while rsp is not stalled; the watchdog state
// updates through a 33-bit saturating add and a 32-bit compare.
// Reset: watchdog state cleared, timeout 2000 ms, cutoff delay 5000 ms, no
// result pending.
// When rsp stalls, the result register holds and one further request waits in
// the input register; req.ready drops only when both are full.
// Depends on fss_pkg, fss_if, fss_cfg_regs and fss_core.
module fan_stall_supervisor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	fss_req_if.sink                        req,
	fss_rsp_if.source                      rsp
);

	fss_pkg::cfg_t cfg;
	fss_pkg::req_t req_s1;
	fss_pkg::rsp_t rsp_comb;
	fss_pkg::rsp_t rsp_q;
	logic          valid_s1;
	logic          rsp_valid_q;
	logic          advance;
	logic          fire;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	fss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fss_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.operation        <= req.operation;
			req_s1.power_on_request <= req.power_on_request;
			req_s1.speed_request    <= req.speed_request;
			req_s1.pulse_count      <= req.pulse_count;
			req_s1.step_ms          <= req.step_ms;
		end
		if (fire) begin
			rsp_q <= rsp_comb;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.power_enable  = rsp_q.power_enable;
	assign rsp.applied_speed = rsp_q.applied_speed;
	assign rsp.fault_new     = rsp_q.fault_new;

endmodule

// ===== rtl/fss_checker.sv =====
// Port-level checker for the fan stall supervisor, bound to the top level.
// Depends on fan_stall_supervisor_unit_assert.svh and fss_pkg.
`include "fan_stall_supervisor_unit_assert.svh"

module fss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_power_enable,
	input logic [6:0] out_applied_speed,
	input logic       out_fault_new
);

	`FSS_ASSERT_NOW(a_speed_range, clk, arst_n, out_valid, out_applied_speed <= fss_pkg::PCT_MAX[6:0])
	`FSS_ASSERT_NOW(a_fault_shape, clk, arst_n, out_valid && out_fault_new, out_power_enable && out_applied_speed == 7'd0)
	`FSS_ASSERT_NOW(a_speed_needs_power, clk, arst_n, out_valid && out_applied_speed != 7'd0, out_power_enable)
	`FSS_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !out_valid, in_ready)
	`FSS_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_applied_speed) && $stable(out_power_enable) && $stable(out_fault_new))

endmodule

bind fan_stall_supervisor_unit fss_checker u_fss_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_ready          (req.ready),
	.out_valid         (rsp.valid),
	.out_ready         (rsp.ready),
	.out_power_enable  (rsp.power_enable),
	.out_applied_speed (rsp.applied_speed),
	.out_fault_new     (rsp.fault_new)
);

// ===== dv/fan_stall_supervisor_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench of fan_stall_supervisor_unit: a directed table and random phases.
// Each result is checked in order: typed rows against the table, others against an in-bench watchdog model.
// Depends on fss_pkg, fss_if and the unit RTL.
module fan_stall_supervisor_unit_tb;

	localparam int IDLE_LIMIT    = 500;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 125;

	localparam logic [31:0] TMO_RST = fss_pkg::TIMEOUT_RESET;
	localparam logic [31:0] CUT_RST = fss_pkg::CUTOFF_RESET;
	localparam logic        STEP    = fss_pkg::OP_STEP;
	localparam logic        CLR     = fss_pkg::OP_CLEAR;

	typedef struct {
		logic [31:0]    stall_limit;
		logic [31:0]    cutoff;
		fss_pkg::req_t  item;
		bit             typed;
		fss_pkg::rsp_t  want;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we;
	logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata;

	fss_req_if req_ch();
	fss_rsp_if rsp_ch();

	fan_stall_supervisor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [31:0] timeout_ms;
	logic [31:0] cutoff_ms;
	logic        pred_fault;
	logic [31:0] cutoff_left;
	logic [31:0] pred_stall_ms;

	fss_pkg::rsp_t expected_q[$];
	row_t          steps[$];
	int            errors = 0;
	int            idle_cycles = 0;
	bit            req_gaps;
	bit            rsp_stalls;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic fss_pkg::rsp_t supervise_step(fss_pkg::req_t r);
		fss_pkg::rsp_t res;
		logic [7:0]    pct;
		logic [32:0]   sum;
		res = '0;
		pct = (r.speed_request > fss_pkg::PCT_MAX) ? fss_pkg::PCT_MAX : r.speed_request;
		if (r.operation == fss_pkg::OP_CLEAR) begin
			pred_fault    = 1'b0;
			cutoff_left   = '0;
			pred_stall_ms = '0;
		end else if (pred_fault) begin
			if (cutoff_left > {16'd0, r.step_ms}) begin
				cutoff_left = cutoff_left - {16'd0, r.step_ms};
				res.power_enable = 1'b1;
			end else begin
				cutoff_left = '0;
			end
		end else if (!r.power_on_request) begin
			pred_stall_ms = '0;
		end else begin
			res.power_enable  = 1'b1;
			res.applied_speed = pct[6:0];
			if (pct == 8'd0 || r.pulse_count != 16'd0) begin
				pred_stall_ms = '0;
			end else begin
				sum = {1'b0, pred_stall_ms} + {17'd0, r.step_ms};
				pred_stall_ms = sum[32] ? '1 : sum[31:0];
				if (pred_stall_ms >= timeout_ms) begin
					pred_fault        = 1'b1;
					cutoff_left       = cutoff_ms;
					res.applied_speed = '0;
					res.fault_new     = 1'b1;
				end
			end
		end
		return res;
	endfunction

	function automatic fss_pkg::req_t make_step(logic op, logic pwr, logic [7:0] pct,
			logic [15:0] pulses, logic [15:0] ms);
		fss_pkg::req_t r;
		r.operation        = op;
		r.power_on_request = pwr;
		r.speed_request    = pct;
		r.pulse_count      = pulses;
		r.step_ms          = ms;
		return r;
	endfunction

	// mostly powered, no-tach runs so faults latch and cutoffs expire; clears and noise mixed in
	function automatic fss_pkg::req_t random_step();
		fss_pkg::req_t r;
		r.operation = ($urandom_range(0, 29) == 0) ? fss_pkg::OP_CLEAR : fss_pkg::OP_STEP;
		if (pred_fault && cutoff_left == 0 && $urandom_range(0, 3) == 0)
			r.operation = fss_pkg::OP_CLEAR;
		r.power_on_request = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 9))
			0: begin
				r.speed_request = 8'd0;
			end
			1: begin
				r.speed_request = 8'($urandom_range(101, 255));
			end
			default: begin
				r.speed_request = 8'($urandom_range(1, 100));
			end
		endcase
		r.pulse_count = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd0;
		r.step_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
		return r;
	endfunction

	task automatic add_row(logic [31:0] t, logic [31:0] c, logic op, logic pwr,
			logic [7:0] pct, logic [15:0] pulses, logic [15:0] ms, bit typed,
			logic pe, logic [6:0] sp, logic fn);
		row_t r;
		r.stall_limit = t;
		r.cutoff      = c;
		r.item        = make_step(op, pwr, pct, pulses, ms);
		r.typed       = typed;
		r.want.power_enable  = pe;
		r.want.applied_speed = sp;
		r.want.fault_new     = fn;
		steps.push_back(r);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic hold_requests(int n);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_step(fss_pkg::req_t r, bit typed, fss_pkg::rsp_t want);
		fss_pkg::rsp_t pred;
		if (req_gaps && $urandom_range(0, 4) == 0)
			hold_requests($urandom_range(1, 4));
		@(negedge clk);
		req_ch.valid            <= 1'b1;
		req_ch.operation        <= r.operation;
		req_ch.power_on_request <= r.power_on_request;
		req_ch.speed_request    <= r.speed_request;
		req_ch.pulse_count      <= r.pulse_count;
		req_ch.step_ms          <= r.step_ms;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pred = supervise_step(r);
		expected_q.push_back(typed ? want : pred);
	endtask

	task automatic drain_results();
		hold_requests(1);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [fss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == fss_pkg::REG_STALL_TIMEOUT)
			timeout_ms = val;
		else
			cutoff_ms = val;
	endtask

	task automatic set_limits(logic [31:0] t, logic [31:0] c);
		drain_results();
		write_reg(fss_pkg::REG_STALL_TIMEOUT, t);
		write_reg(fss_pkg::REG_CUTOFF_DELAY, c);
	endtask

	task automatic build_directed_table();
		add_row(TMO_RST, CUT_RST, CLR, 1, 255, 16'hffff, 16'hffff, 1, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 0, 255, 0, 16'hffff, 1, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 255, 1, 16'hffff, 1, 1, 100, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 100, 0, 1999, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 50, 0, 1, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 255, 0, 4999, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 100, 0, 1, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, CLR, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 0, 0, 16'hffff, 1, 1, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 101, 0, 1000, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 100, 16'hffff, 1000, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 1, 0, 1500, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 0, 127, 0, 100, 1, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 1, 0, 1999, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 1, 0, 0, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, STEP, 1, 128, 0, 1, 0, 0, 0, 0);
		add_row(TMO_RST, CUT_RST, CLR, 0, 0, 0, 0, 1, 0, 0, 0);
		// zero timeout: fault on the first powered no-tach step, even with no time elapsed
		add_row(0, 0, STEP, 1, 1, 0, 0, 1, 1, 0, 1);
		add_row(0, 0, STEP, 1, 100, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, CLR, 1, 100, 0, 0, 1, 0, 0, 0);
		add_row(0, 0, STEP, 1, 0, 0, 0, 1, 1, 0, 0);
		add_row(0, 0, STEP, 1, 7, 3, 0, 1, 1, 7, 0);
		add_row(0, 0, STEP, 0, 100, 0, 0, 1, 0, 0, 0);
		add_row(0, 0, STEP, 1, 200, 0, 16'hffff, 0, 0, 0, 0);
	endtask

	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_stalls && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				rsp_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		fss_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unrequested result", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.power_enable !== want.power_enable)
					report_mismatch("power_enable", rsp_ch.power_enable, want.power_enable);
				if (rsp_ch.applied_speed !== want.applied_speed)
					report_mismatch("applied_speed", rsp_ch.applied_speed, want.applied_speed);
				if (rsp_ch.fault_new !== want.fault_new)
					report_mismatch("fault_new", rsp_ch.fault_new, want.fault_new);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		cfg_we                  = 1'b0;
		cfg_index               = '0;
		cfg_wdata               = '0;
		req_ch.valid            = 1'b0;
		req_ch.operation        = fss_pkg::OP_STEP;
		req_ch.power_on_request = 1'b0;
		req_ch.speed_request    = '0;
		req_ch.pulse_count      = '0;
		req_ch.step_ms          = '0;
		timeout_ms              = fss_pkg::TIMEOUT_RESET;
		cutoff_ms               = fss_pkg::CUTOFF_RESET;
		pred_fault              = 1'b0;
		cutoff_left             = '0;
		pred_stall_ms           = '0;
		req_gaps                = 1'b1;
		rsp_stalls              = 1'b1;
		build_directed_table();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].stall_limit != timeout_ms || steps[i].cutoff != cutoff_ms)
				set_limits(steps[i].stall_limit, steps[i].cutoff);
			send_step(steps[i].item, steps[i].typed, steps[i].want);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			req_gaps   = (p != 1) && (p != RANDOM_PHASES - 1);
			rsp_stalls = req_gaps;
			if (p == 3)
				set_limits($urandom, $urandom);
			else
				set_limits($urandom_range(0, 3000), $urandom_range(0, 4000));
			repeat (PHASE_ITEMS)
				send_step(random_step(), 0, '0);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fss_pkg.sv
rtl/fss_if.sv
rtl/fss_cfg_regs.sv
rtl/fss_core.sv
rtl/fan_stall_supervisor_unit.sv
rtl/fss_checker.sv
dv/fan_stall_supervisor_unit_tb.sv
